>>> rtl/histogram_vertex_z_finder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the vertex finder modules
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_VERTEX_Z_FINDER_UNIT_MACROS_SVH
`define HISTOGRAM_VERTEX_Z_FINDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define HVZF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);
// checked on every edge, reset included
`define HVZF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
	else $error(msg);
`else
`define HVZF_ASSERT(lbl, prop, msg)
`define HVZF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/hvzf_pkg.sv
// ----------------------------------------------------------------------------
// hvzf_pkg
// Shared types and constants of the histogram vertex z finder.
// ----------------------------------------------------------------------------
package hvzf_pkg;

	localparam int unsigned MAX_TRACKS_DEF = 256;
	localparam int unsigned MAX_BINS_DEF   = 512;

	localparam int unsigned Z_W     = 12;
	localparam int unsigned PT_W    = 12;
	localparam int unsigned BW_W    = 11;
	localparam int unsigned RNG_W   = 11;
	localparam int unsigned PTL_W   = 12;
	localparam int unsigned BIN_W   = 20;
	localparam int unsigned SUM_W   = 22;
	localparam int unsigned CB_W    = 10;
	localparam int unsigned CFG_W   = 12;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	localparam logic [BW_W-1:0]  BIN_WIDTH_RST    = 11'd13;
	localparam logic [RNG_W-1:0] Z_HALF_RANGE_RST = 11'd1920;
	localparam logic [PTL_W-1:0] PT_LIMIT_RST     = 12'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIN_WIDTH    = 2'd0,
		REG_Z_HALF_RANGE = 2'd1,
		REG_PT_LIMIT     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BW_W-1:0]  bin_width;
		logic [RNG_W-1:0] z_half_range;
		logic [PTL_W-1:0] pt_limit;
	} cfg_t;

	typedef struct packed {
		logic [Z_W-1:0]  z0;
		logic [PT_W-1:0] pt;
		logic            last;
		logic            drop;
	} track_item_t;

	typedef struct packed {
		logic [Z_W-1:0]   vertex_z;
		logic [SUM_W-1:0] window_pt_sum;
		logic [CB_W-1:0]  centre_bin;
		logic             empty_selection;
		logic             track_overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BIN_START,
		ST_BIN_RUN,
		ST_SEL,
		ST_DIV_INIT,
		ST_DIV,
		ST_OUT
	} back_state_t;

endpackage

>>> rtl/hvzf_front.sv
// ----------------------------------------------------------------------------
// hvzf_front
// Accepts tracks, marks those beyond the per-event limit for dropping and
// queues them for the back end.
// ----------------------------------------------------------------------------
`include "histogram_vertex_z_finder_unit_macros.svh"

module hvzf_front #(
	parameter int unsigned MAX_TRACKS = hvzf_pkg::MAX_TRACKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hvzf_pkg::Z_W-1:0]    track_z0,
	input  logic [hvzf_pkg::PT_W-1:0]   track_pt,
	input  logic                        last_track,
	output logic                        q_valid,
	input  logic                        q_ready,
	output hvzf_pkg::track_item_t       q_item
);

	localparam int unsigned TCW = $clog2(MAX_TRACKS + 1);

	hvzf_pkg::track_item_t         fifo_q [hvzf_pkg::QUEUE_DEPTH];
	logic [hvzf_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [hvzf_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [hvzf_pkg::QUEUE_AW:0]   count_q;
	logic [TCW-1:0]                ev_cnt_q;
	logic                          push;
	logic                          pop;
	logic                          drop;

	assign in_ready = count_q != (hvzf_pkg::QUEUE_AW + 1)'(hvzf_pkg::QUEUE_DEPTH);
	assign q_valid  = count_q != '0;
	assign q_item   = fifo_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign drop     = ev_cnt_q == TCW'(MAX_TRACKS);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{z0: track_z0, pt: track_pt, last: last_track, drop: drop};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			ev_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				// restart the count at each event boundary, hold at the limit
				if (last_track) begin
					ev_cnt_q <= '0;
				end else if (!drop) begin
					ev_cnt_q <= ev_cnt_q + 1'b1;
				end
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`HVZF_ASSERT_ALWAYS(a_queue_bound,
		count_q <= (hvzf_pkg::QUEUE_AW + 1)'(hvzf_pkg::QUEUE_DEPTH), "queue overfilled")
	`HVZF_ASSERT_ALWAYS(a_event_count_bound, ev_cnt_q <= TCW'(MAX_TRACKS),
		"event track count past limit")
	`HVZF_ASSERT(a_event_restart, push && last_track |=> ev_cnt_q == '0,
		"event count not restarted")
	`HVZF_ASSERT(a_queue_hold, q_valid && !q_ready && !push |=> $stable(count_q),
		"queue level moved without traffic")

endmodule

>>> rtl/hvzf_div.sv
// ----------------------------------------------------------------------------
// hvzf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hvzf_div #(
	parameter int unsigned NUM_W = 33,
	parameter int unsigned DEN_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial    = {rem_q, quo_q[NUM_W-1]};
	assign diff     = trial - {1'b0, den_q};
	assign ge       = trial >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/hvzf_back.sv
// ----------------------------------------------------------------------------
// hvzf_back
// Stores the tracks of an event, scans the histogram bin by bin, tracks the
// best three-bin window, sums the selected tracks and divides.
// ----------------------------------------------------------------------------
`include "histogram_vertex_z_finder_unit_macros.svh"

module hvzf_back #(
	parameter int unsigned MAX_TRACKS = hvzf_pkg::MAX_TRACKS_DEF,
	parameter int unsigned MAX_BINS   = hvzf_pkg::MAX_BINS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hvzf_pkg::cfg_t        cfg,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  hvzf_pkg::track_item_t q_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hvzf_pkg::result_t     result
);

	localparam int unsigned ZW  = hvzf_pkg::Z_W;
	localparam int unsigned PW  = hvzf_pkg::PT_W;
	localparam int unsigned BW  = hvzf_pkg::BIN_W;
	localparam int unsigned SW  = hvzf_pkg::SUM_W;
	localparam int unsigned TAW = $clog2(MAX_TRACKS);
	localparam int unsigned TCW = $clog2(MAX_TRACKS + 1);
	localparam int unsigned BCW = $clog2(MAX_BINS + 1);
	localparam int unsigned CW  = BCW + 15;
	localparam int unsigned NW  = ZW + PW + TCW;
	localparam int unsigned DW  = PW + TCW;

	hvzf_pkg::back_state_t state_q, state_d;

	logic [ZW+PW-1:0] track_mem [MAX_TRACKS];
	logic [ZW+PW-1:0] rd_data_s1;

	logic [TCW-1:0]        cnt_q;
	logic                  ovf_q;
	logic [TCW-1:0]        rd_idx_q;
	logic                  v_s1;
	logic                  last_s1;
	logic                  v_s2;
	logic                  last_s2;
	logic signed [ZW+PW:0] prod_s2;
	logic [PW-1:0]         pt_s2;

	logic [BCW-1:0]       jcnt_q;
	logic [CW-1:0]        jw_q;
	logic signed [CW-1:0] c2_q;
	logic signed [CW-1:0] bestref_q;
	logic [BW-1:0]        sum_q;
	logic [BW-1:0]        p1_q;
	logic [BW-1:0]        p2_q;
	logic [SW-1:0]        best_q;
	logic signed [BCW:0]  best_i_q;
	logic signed [NW-1:0] num_q;
	logic [DW-1:0]        den_q;
	logic                 out_valid_q;
	hvzf_pkg::result_t    result_q;

	logic                  pop;
	logic                  issue;
	logic                  div_start;
	logic                  div_done;
	logic [NW-1:0]         quo;
	logic [NW-1:0]         num_mag;
	logic                  bin_more;
	logic signed [ZW-1:0]  z1;
	logic [PW-1:0]         pt1;
	logic signed [CW-1:0]  z1d;
	logic signed [CW-1:0]  dbin;
	logic [CW-1:0]         dbin_abs;
	logic signed [CW-1:0]  dsel;
	logic [CW-1:0]         dsel_abs;
	logic [CW-1:0]         w2;
	logic [CW-1:0]         w3;
	logic                  hit;
	logic                  sel;
	logic [BW:0]           sum_add;
	logic [BW-1:0]         sum_sat;
	logic [BW-1:0]         sum_nxt;
	logic [SW-1:0]         cur;
	logic signed [ZW+PW:0] prod;
	logic [ZW-1:0]         vz_mag;
	logic signed [31:0]    best_i_ext;
	logic signed [CW-1:0]  c2_init;
	logic signed [CW-1:0]  ref_init;

	// ---- stored tracks: one write port, one registered read port ----
	always_ff @(posedge clk) begin
		if (pop && !q_item.drop) begin
			track_mem[cnt_q[TAW-1:0]] <= {q_item.z0, q_item.pt};
		end
		rd_data_s1 <= track_mem[rd_idx_q[TAW-1:0]];
	end

	// ---- per-track tests on the read data ----
	assign z1       = $signed(rd_data_s1[ZW+PW-1:PW]);
	assign pt1      = rd_data_s1[PW-1:0];
	assign z1d      = CW'(z1) <<< 1;
	assign w2       = CW'({cfg.bin_width, 1'b0});
	assign w3       = w2 + CW'(cfg.bin_width);
	assign dbin     = c2_q - z1d;
	assign dbin_abs = dbin[CW-1] ? CW'(-dbin) : CW'(dbin);
	assign dsel     = z1d - bestref_q;
	assign dsel_abs = dsel[CW-1] ? CW'(-dsel) : CW'(dsel);
	assign hit      = (pt1 < cfg.pt_limit) && (dbin_abs < w2);
	assign sel      = dsel_abs < w3;
	assign prod     = z1 * $signed({1'b0, pt1});

	assign sum_add = {1'b0, sum_q} + (BW + 1)'(pt1);
	assign sum_sat = sum_add[BW] ? {BW{1'b1}} : sum_add[BW-1:0];
	assign sum_nxt = (v_s1 && hit) ? sum_sat : sum_q;
	assign cur     = SW'(sum_nxt) + SW'(p1_q) + SW'(p2_q);

	assign bin_more = (jcnt_q < BCW'(MAX_BINS)) &&
		(jw_q < CW'({cfg.z_half_range, 1'b0}) + CW'(cfg.bin_width));
	assign c2_init  = CW'(0) - CW'({cfg.z_half_range, 1'b0}) - CW'(cfg.bin_width);
	assign ref_init = CW'(0) - CW'({cfg.z_half_range, 1'b0});

	assign num_mag    = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
	assign vz_mag     = quo[ZW-1:0];
	assign best_i_ext = 32'(best_i_q);

	hvzf_div #(
		.NUM_W (NW),
		.DEN_W (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_mag),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quo)
	);

	// ---- sequencer ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hvzf_pkg::ST_LOAD: begin
				if (pop && q_item.last) state_d = hvzf_pkg::ST_BIN_START;
			end
			hvzf_pkg::ST_BIN_START: begin
				state_d = bin_more ? hvzf_pkg::ST_BIN_RUN : hvzf_pkg::ST_SEL;
			end
			hvzf_pkg::ST_BIN_RUN: begin
				if (v_s1 && last_s1) state_d = hvzf_pkg::ST_BIN_START;
			end
			hvzf_pkg::ST_SEL: begin
				if (v_s2 && last_s2) state_d = hvzf_pkg::ST_DIV_INIT;
			end
			hvzf_pkg::ST_DIV_INIT: state_d = hvzf_pkg::ST_DIV;
			hvzf_pkg::ST_DIV: begin
				if (div_done) state_d = hvzf_pkg::ST_OUT;
			end
			hvzf_pkg::ST_OUT: begin
				if (!out_valid_q) state_d = hvzf_pkg::ST_LOAD;
			end
			default: state_d = hvzf_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		q_ready   = state_q == hvzf_pkg::ST_LOAD;
		issue     = (state_q == hvzf_pkg::ST_BIN_RUN || state_q == hvzf_pkg::ST_SEL) &&
			(rd_idx_q < cnt_q);
		div_start = state_q == hvzf_pkg::ST_DIV_INIT;
	end

	assign pop       = q_valid && q_ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hvzf_pkg::ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1 && state_q == hvzf_pkg::ST_SEL;
			if (pop) begin
				if (q_item.drop) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == hvzf_pkg::ST_OUT && !out_valid_q) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= (rd_idx_q + TCW'(1)) == cnt_q;
		last_s2 <= last_s1;
		prod_s2 <= sel ? prod : '0;
		pt_s2   <= sel ? pt1 : '0;
		if (issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (v_s2) begin
			num_q <= num_q + NW'(prod_s2);
			den_q <= den_q + DW'(pt_s2);
		end
		unique case (state_q)
			hvzf_pkg::ST_LOAD: begin
				// prime the scan for the next event
				jcnt_q    <= '0;
				jw_q      <= '0;
				c2_q      <= c2_init;
				bestref_q <= ref_init;
				p1_q      <= '0;
				p2_q      <= '0;
				best_q    <= '0;
				best_i_q  <= '0;
			end
			hvzf_pkg::ST_BIN_START: begin
				rd_idx_q <= '0;
				sum_q    <= '0;
				num_q    <= '0;
				den_q    <= '0;
			end
			hvzf_pkg::ST_BIN_RUN: begin
				sum_q <= sum_nxt;
				if (v_s1 && last_s1) begin
					// close this bin and slide the three-bin window
					if (cur > best_q) begin
						best_q    <= cur;
						best_i_q  <= $signed({1'b0, jcnt_q}) - (BCW + 1)'(1);
						bestref_q <= c2_q - CW'(cfg.bin_width);
					end
					p2_q   <= p1_q;
					p1_q   <= sum_nxt;
					jcnt_q <= jcnt_q + 1'b1;
					jw_q   <= jw_q + CW'(cfg.bin_width);
					c2_q   <= c2_q + $signed(w2);
				end
			end
			hvzf_pkg::ST_OUT: begin
				if (!out_valid_q) begin
					result_q.window_pt_sum   <= best_q;
					result_q.centre_bin      <= best_i_ext[hvzf_pkg::CB_W-1:0];
					result_q.track_overflow  <= ovf_q;
					result_q.empty_selection <= den_q == '0;
					if (den_q == '0) begin
						result_q.vertex_z <= '0;
					end else begin
						result_q.vertex_z <= num_q[NW-1] ? ZW'(-vz_mag) : vz_mag;
					end
				end
			end
			default: begin
			end
		endcase
	end

	`HVZF_ASSERT_ALWAYS(a_count_bound, cnt_q <= TCW'(MAX_TRACKS), "track count past limit")
	`HVZF_ASSERT(a_div_done_state, div_done |-> state_q == hvzf_pkg::ST_DIV,
		"divider finished outside its wait")
	`HVZF_ASSERT(a_result_issue, state_q == hvzf_pkg::ST_OUT && !out_valid_q |=>
		out_valid_q && state_q == hvzf_pkg::ST_LOAD && cnt_q == '0, "result not issued")
	`HVZF_ASSERT(a_sel_pipe, v_s2 |-> $past(state_q) == hvzf_pkg::ST_SEL,
		"selection data outside selection pass")

endmodule

>>> rtl/histogram_vertex_z_finder_unit.sv
// ----------------------------------------------------------------------------
// histogram_vertex_z_finder_unit
// Histogram primary vertex finder: collects an event's tracks and returns the
// pt-weighted z of the tracks around the densest three-bin window.
//
//  channel   signals                                   direction
//  track     in_valid/in_ready, track_z0/pt, last      in
//  vertex    out_valid/out_ready, vertex_z .. overflow out
//  config    wr_en, wr_index, wr_data                  in, write only
//
// Tracks load at one per cycle through a four-entry queue while it has room.
// The last track starts the search: the bin scan reads the track memory once
// per bin on its one port.
// Reset (arst_n) empties the queue and clears the event; configuration
// registers return to bin_width 13, z_half_range 1920, pt_limit 200.
// A stalled result holds in its register while the next event loads.
// ----------------------------------------------------------------------------
module histogram_vertex_z_finder_unit #(
	parameter int unsigned MAX_TRACKS = hvzf_pkg::MAX_TRACKS_DEF,
	parameter int unsigned MAX_BINS   = hvzf_pkg::MAX_BINS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [hvzf_pkg::Z_W-1:0]         track_z0,
	input  logic [hvzf_pkg::PT_W-1:0]        track_pt,
	input  logic                             last_track,
	input  logic                             wr_en,
	input  logic [hvzf_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [hvzf_pkg::CFG_W-1:0]       wr_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [hvzf_pkg::Z_W-1:0]         vertex_z,
	output logic [hvzf_pkg::SUM_W-1:0]       window_pt_sum,
	output logic [hvzf_pkg::CB_W-1:0]        centre_bin,
	output logic                             empty_selection,
	output logic                             track_overflow
);

	hvzf_pkg::cfg_t        cfg_q;
	hvzf_pkg::track_item_t q_item;
	hvzf_pkg::result_t     result;
	logic                  q_valid;
	logic                  q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bin_width    <= hvzf_pkg::BIN_WIDTH_RST;
			cfg_q.z_half_range <= hvzf_pkg::Z_HALF_RANGE_RST;
			cfg_q.pt_limit     <= hvzf_pkg::PT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (hvzf_pkg::cfg_reg_t'(wr_index))
				hvzf_pkg::REG_BIN_WIDTH:    cfg_q.bin_width    <= wr_data[hvzf_pkg::BW_W-1:0];
				hvzf_pkg::REG_Z_HALF_RANGE: cfg_q.z_half_range <= wr_data[hvzf_pkg::RNG_W-1:0];
				hvzf_pkg::REG_PT_LIMIT:     cfg_q.pt_limit     <= wr_data[hvzf_pkg::PTL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	hvzf_front #(
		.MAX_TRACKS (MAX_TRACKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.track_z0   (track_z0),
		.track_pt   (track_pt),
		.last_track (last_track),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item)
	);

	hvzf_back #(
		.MAX_TRACKS (MAX_TRACKS),
		.MAX_BINS   (MAX_BINS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign vertex_z        = result.vertex_z;
	assign window_pt_sum   = result.window_pt_sum;
	assign centre_bin      = result.centre_bin;
	assign empty_selection = result.empty_selection;
	assign track_overflow  = result.track_overflow;

endmodule
